// ===== rtl/core/buis_pkg.sv =====
// Shared constants, types and helper functions of the bounded uniform integer sampler.
package buis_pkg;

  localparam int WORD_BITS     = 32;
  localparam int MAX_DRAW_BITS = 64;
  localparam int VAL_BITS      = 64;
  localparam int MAX_RESULTS   = 32;
  localparam int RES_BITS      = MAX_DRAW_BITS + WORD_BITS;
  localparam int CNT_W         = $clog2(RES_BITS + 1);
  localparam int WANT_W        = $clog2(VAL_BITS + 1);
  localparam int NRES_W        = $clog2(MAX_RESULTS + 1);
  localparam int NBYTES        = VAL_BITS / 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  // cycles from a register write until the derived range settles
  localparam int DERIVE_LAT    = 4;
  localparam int BUSY_W        = $clog2(DERIVE_LAT + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW    = 2'd0,
    CFG_HIGH   = 2'd1,
    CFG_SIGNED = 2'd2
  } buis_cfg_idx_e;

  // settled range description handed from front to back
  typedef struct packed {
    logic [VAL_BITS-1:0] lo;
    logic [VAL_BITS-1:0] range;
    logic [WANT_W-1:0]   want;
    logic                zero;
  } buis_range_t;

  // mask of the n low bits, n up to the full value width
  function automatic logic [VAL_BITS-1:0] low_mask(input logic [WANT_W-1:0] n);
    logic [VAL_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < VAL_BITS; i++) begin
      if (i < int'(n)) m[i] = 1'b1;
    end
    return m;
  endfunction

  // bit width of one byte, 0..8
  function automatic logic [3:0] byte_width(input logic [7:0] b);
    logic [3:0] w;
    w = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) w = 4'(i + 1);
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/buis_if.sv =====
// Valid/ready channel interfaces: random words in, samples out, register writes.
interface bus_word_if;
  import buis_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] random_word;
  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface bus_sample_if;
  import buis_pkg::*;
  logic                valid;
  logic                ready;
  logic [VAL_BITS-1:0] sample_value;
  logic                last_of_word;
  modport source (output valid, output sample_value, output last_of_word, input ready);
  modport sink   (input valid, input sample_value, input last_of_word, output ready);
endinterface

interface bus_cfg_if;
  import buis_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/buis_front.sv =====
// Front end: configuration registers, range derivation pipeline, word intake.
module buis_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bus_cfg_if.sink                          cfg,
  input  logic                             word_valid_i,
  output logic                             word_ready_o,
  input  logic [buis_pkg::WORD_BITS-1:0]   word_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output logic [buis_pkg::WORD_BITS-1:0]   q_data_o,
  output buis_pkg::buis_range_t            range_o
);
  import buis_pkg::*;

  logic [VAL_BITS-1:0] low_q, high_q;
  logic                signed_q;
  logic [BUSY_W-1:0]   busy_q;

  logic [VAL_BITS-1:0] s1_lo_q, s1_hi_q;
  logic [VAL_BITS-1:0] s2_lo_q, s2_range_q;
  logic [VAL_BITS-1:0] s3_lo_q, s3_range_q;
  logic [NBYTES-1:0]   s3_nz_q;
  logic [3:0]          s3_bw_q [NBYTES];
  buis_range_t         s4_q;

  logic                cfg_wr;
  logic [VAL_BITS-1:0] flip;
  logic [WANT_W-1:0]   want_raw;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= '0;
      high_q   <= VAL_BITS'(255);
      signed_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        CFG_LOW:    low_q    <= cfg.data;
        CFG_HIGH:   high_q   <= cfg.data;
        CFG_SIGNED: signed_q <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // hold off words until the derived range has settled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= BUSY_W'(DERIVE_LAT);
    end else if (cfg_wr) begin
      busy_q <= BUSY_W'(DERIVE_LAT);
    end else if (busy_q != '0) begin
      busy_q <= busy_q - 1'b1;
    end
  end

  assign flip = signed_q ? {1'b1, {(VAL_BITS-1){1'b0}}} : '0;

  // effective bound width, highest nonzero byte wins
  always_comb begin
    want_raw = '0;
    for (int b = 0; b < NBYTES; b++) begin
      if (s3_nz_q[b]) want_raw = WANT_W'(b * 8) + WANT_W'(s3_bw_q[b]);
    end
    if (want_raw > WANT_W'(MAX_DRAW_BITS)) want_raw = WANT_W'(MAX_DRAW_BITS);
  end

  // free-running derivation: select, subtract, byte widths, combine
  always_ff @(posedge clk_i) begin
    s1_hi_q    <= high_q;
    s1_lo_q    <= ((low_q ^ flip) > (high_q ^ flip)) ? high_q : low_q;
    s2_lo_q    <= s1_lo_q;
    s2_range_q <= s1_hi_q - s1_lo_q;
    s3_lo_q    <= s2_lo_q;
    s3_range_q <= s2_range_q;
    for (int b = 0; b < NBYTES; b++) begin
      s3_nz_q[b] <= |s2_range_q[b*8 +: 8];
      s3_bw_q[b] <= byte_width(s2_range_q[b*8 +: 8]);
    end
    s4_q.lo    <= s3_lo_q;
    s4_q.range <= s3_range_q;
    s4_q.want  <= want_raw;
    s4_q.zero  <= (s3_nz_q == '0);
  end

  assign range_o      = s4_q;
  assign word_ready_o = !q_full_i && (busy_q == '0);
  assign q_push_o     = word_valid_i && word_ready_o;
  assign q_data_o     = word_i;

endmodule

// ===== rtl/core/buis_queue.sv =====
// Short word queue between front and back.
module buis_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [buis_pkg::WORD_BITS-1:0] data_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic [buis_pkg::WORD_BITS-1:0] data_o,
  output logic                           empty_o
);
  import buis_pkg::*;

  logic [WORD_BITS-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wptr_q, rptr_q;
  logic [QCNT_W-1:0]    cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ptr_inc(wptr_q);
      if (pop_i)  rptr_q <= ptr_inc(rptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

// ===== rtl/core/buis_back.sv =====
// Back end: bit reservoir, candidate draw and accept, result hold and output register.
module buis_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  buis_pkg::buis_range_t          range_i,
  input  logic                           q_empty_i,
  input  logic [buis_pkg::WORD_BITS-1:0] q_data_i,
  output logic                           q_pop_o,
  bus_sample_if.source                   sample_out
);
  import buis_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [RES_BITS-1:0]  res_q, res_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [NRES_W-1:0]    nres_q, nres_d;
  logic                 zero_q, zero_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [VAL_BITS-1:0]  pend_q, pend_d;
  logic                 out_vld_q, out_vld_d;
  logic [VAL_BITS-1:0]  out_val_q, out_val_d;
  logic                 out_last_q, out_last_d;

  logic                 out_free;
  logic [CNT_W-1:0]     room, take;
  logic [WORD_BITS-1:0] word_m;
  logic [VAL_BITS-1:0]  cand, sum;
  logic                 can_draw, acc;

  assign out_free = !out_vld_q || sample_out.ready;

  // append arithmetic
  always_comb begin
    room   = CNT_W'(RES_BITS) - cnt_q;
    take   = (room < CNT_W'(WORD_BITS)) ? room : CNT_W'(WORD_BITS);
    word_m = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (i < int'(take)) word_m[i] = q_data_i[i];
    end
  end

  // candidate from the low end of the reservoir
  assign cand     = res_q[VAL_BITS-1:0] & low_mask(range_i.want);
  assign sum      = range_i.lo + cand;
  assign acc      = (cand <= range_i.range);
  assign can_draw = !zero_q && (cnt_q >= CNT_W'(range_i.want)) &&
                    (nres_q < NRES_W'(MAX_RESULTS));

  // sequencer
  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    nres_d     = nres_q;
    zero_d     = zero_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = sample_out.ready ? 1'b0 : out_vld_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;
    q_pop_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          res_d   = res_q | ({{(RES_BITS-WORD_BITS){1'b0}}, word_m} << cnt_q);
          cnt_d   = cnt_q + take;
          nres_d  = '0;
          zero_d  = range_i.zero;
          // a zero range yields low once, without drawing
          pend_vld_d = range_i.zero;
          pend_d     = range_i.lo;
          state_d    = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (can_draw) begin
          if (!(acc && pend_vld_q && !out_free)) begin
            res_d = res_q >> range_i.want;
            cnt_d = cnt_q - CNT_W'(range_i.want);
            if (acc) begin
              if (pend_vld_q) begin
                out_vld_d  = 1'b1;
                out_val_d  = pend_q;
                out_last_d = 1'b0;
              end
              pend_vld_d = 1'b1;
              pend_d     = sum;
              nres_d     = nres_q + 1'b1;
            end
          end
        end else if (pend_vld_q) begin
          // word exhausted or result limit reached: release the held result as last
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_val_d  = pend_q;
            out_last_d = 1'b1;
            pend_vld_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      res_q      <= '0;
      cnt_q      <= '0;
      nres_q     <= '0;
      zero_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      res_q      <= res_d;
      cnt_q      <= cnt_d;
      nres_q     <= nres_d;
      zero_q     <= zero_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign sample_out.valid        = out_vld_q;
  assign sample_out.sample_value = out_val_q;
  assign sample_out.last_of_word = out_last_q;

endmodule

// ===== rtl/core/bounded_uniform_integer_sampler.sv =====
// Top level of the bounded uniform integer sampler.
//
// Channels: word_in takes 32-bit random words, sample_out delivers 64-bit
// samples in [low, high] with last_of_word set on the final sample of a
// word, cfg writes low_bound (0), high_bound (1) and signed_bounds (2).
// A beat moves on any channel when valid and ready are both high.
// Each word is appended LSB first to a 96-bit reservoir; candidates of the
// range's bit width are drawn from it, and those above the range dropped.
// A word loads into the reservoir as it leaves the queue, once the back end is
// idle; its candidates then pass through the draw shifter, and its last sample
// is released once no more can be drawn, one sample per cycle at most. The last
// sample of a word moves from the held register to the output register after
// its final draw; earlier ones as soon as the next is found.
// After reset and after any register write, word_in.ready is low while the
// range derivation settles; the reservoir starts empty.
// If the receiver stalls, the output register and one held sample stop the
// draw; the two-word queue keeps taking words until full.
module bounded_uniform_integer_sampler (
  input  logic          clk_i,
  input  logic          rst_ni,
  bus_word_if.sink      word_in,
  bus_cfg_if.sink       cfg,
  bus_sample_if.source  sample_out
);
  import buis_pkg::*;

  logic                 q_push, q_pop, q_full, q_empty;
  logic [WORD_BITS-1:0] q_wdata, q_rdata;
  buis_range_t          range;

  buis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg          (cfg),
    .word_valid_i (word_in.valid),
    .word_ready_o (word_in.ready),
    .word_i       (word_in.random_word),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata),
    .range_o      (range)
  );

  buis_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  buis_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .range_i    (range),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .sample_out (sample_out)
  );

endmodule

// ===== rtl/core/buis_checker.sv =====
// Port-level checks of the sampler and their bind to the top level.
module buis_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          word_ready,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [buis_pkg::VAL_BITS-1:0] out_value,
  input logic                          out_last
);
  import buis_pkg::*;

  // a stalled sample stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("sample dropped while stalled");

  // a stalled sample keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_last))
    else $error("sample payload changed while stalled");

  // a register write blocks new words while the range settles
  a_cfg_blocks_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid && cfg_ready |=> !word_ready ##1 !word_ready)
    else $error("word intake open during range update");

  // first cycle out of reset: no sample, no intake
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid && !word_ready)
    else $error("activity right after reset");

endmodule

bind bounded_uniform_integer_sampler buis_checker u_buis_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .word_ready (word_in.ready),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready),
  .out_valid  (sample_out.valid),
  .out_ready  (sample_out.ready),
  .out_value  (sample_out.sample_value),
  .out_last   (sample_out.last_of_word)
);
